// File: rtl/sorted_list_insert_remove_max_assert.svh
// Assertion macros for the sorted list block
// Relies on clk and rst_n being in scope where a macro is used
`ifndef SORTED_LIST_INSERT_REMOVE_MAX_ASSERT_SVH
`define SORTED_LIST_INSERT_REMOVE_MAX_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define SLIRM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the following cycle
`define SLIRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SLIRM_ASSERT_SAME(label, ante, cons, msg)
`define SLIRM_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: rtl/slirm_pkg.sv
// Types and constants shared by the sorted list cells and top level
// No dependencies
`default_nettype none
package slirm_pkg;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        action_t                     action;
        logic signed [VALUE_W-1:0]   value;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]   removed_value;
        status_t                     status;
        logic [COUNT_W-1:0]          entry_count;
        logic                        is_empty;
    } result_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic                        ins;
        logic                        rem;
        logic signed [VALUE_W-1:0]   value;
    } cmd_t;
endpackage
`default_nettype wire

// File: rtl/slirm_cell.sv
// One cell of the sorted chain: holds one entry, largest value in cell 0
// Depends on slirm_pkg
`default_nettype none
module slirm_cell #(
    parameter int CNT_W = 5,
    parameter int INDEX = 0
) (
    input  wire logic                                 clk,
    input  wire slirm_pkg::cmd_t                      cmd,
    input  wire logic [CNT_W-1:0]                     count,
    input  wire logic signed [slirm_pkg::VALUE_W-1:0] left_entry,
    input  wire logic                                 left_shift,
    input  wire logic signed [slirm_pkg::VALUE_W-1:0] right_entry,
    output logic signed [slirm_pkg::VALUE_W-1:0]      entry,
    output logic                                      shift
);
    import slirm_pkg::*;

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;
    logic                      occupied;
    logic                      tail;

    // position of this cell against the fill level
    assign occupied = count > CNT_W'(INDEX);
    assign tail     = count == CNT_W'(INDEX);

    // entries are kept descending, so a smaller entry moves one place down
    assign shift = occupied && (entry_reg < cmd.value);

    // insert takes the neighbor's entry or the new value, remove pulls from the right
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins && (shift || tail))
        begin
            entry_next = left_shift ? left_entry : cmd.value;
        end
        else if (cmd.rem)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
endmodule
`default_nettype wire

// File: rtl/sorted_list_insert_remove_max.sv
// Sorted store of signed values with insert and remove-largest
// A row of slirm_cell instances holds the entries; depends on slirm_pkg
// and sorted_list_insert_remove_max_assert.svh
//
// Usage: an item transaction (item, item_valid, item_stall) carries an
// action and a value. Each accepted item yields exactly one result
// transaction (result, result_valid, result_stall) with the removed value,
// status, count after the item and an empty flag.
// Latency: the result is valid the cycle after the item is accepted.
// Throughput: one item per cycle while no result is held back; every cell compares its entry with the
// new value and shifts in that same cycle, so the chain never iterates.
// Entries are held largest first, so a remove always reads cell 0.
// A full store rejects inserts with status full; an empty store answers
// a remove with status empty and a zero value.
// Stall: while a result waits under result_stall, item_stall is raised and
// no new item is taken; the result register holds its value.
// Reset: the count and the result valid clear; cell contents are unknown
// until written and are never read before that.
`default_nettype none
`include "sorted_list_insert_remove_max_assert.svh"
module sorted_list_insert_remove_max #(
    parameter int CAPACITY = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire slirm_pkg::item_t  item,
    input  wire logic              item_valid,
    output logic                   item_stall,
    output slirm_pkg::result_t     result,
    output logic                   result_valid,
    input  wire logic              result_stall
);
    import slirm_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              result_valid_reg;
    logic              result_valid_next;
    result_t           result_reg;
    result_t           result_next;
    logic              accept;
    logic              full;
    logic              empty;
    cmd_t              cmd;

    logic signed [VALUE_W-1:0] entry_w [CAPACITY];
    logic                      shift_w [CAPACITY];

    // handshake: take an item unless a finished result is held back
    assign item_stall = result_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;
    assign full       = count_reg == CAP_CNT;
    assign empty      = count_reg == '0;

    // command broadcast to the cells
    always_comb
    begin
        cmd.ins   = accept && (item.action == ACT_INSERT) && !full;
        cmd.rem   = accept && (item.action == ACT_REMOVE) && !empty;
        cmd.value = item.value;
    end

    // chain of cells, neighbor links at both ends tied off
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_entry;
        logic                      left_shift;
        logic signed [VALUE_W-1:0] right_entry;

        if (i == 0)
        begin : g_first
            assign left_entry = '0;
            assign left_shift = 1'b0;
        end
        else
        begin : g_mid
            assign left_entry = entry_w[i-1];
            assign left_shift = shift_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_entry = '0;
        end
        else
        begin : g_inner
            assign right_entry = entry_w[i+1];
        end

        slirm_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .count       (count_reg),
            .left_entry  (left_entry),
            .left_shift  (left_shift),
            .right_entry (right_entry),
            .entry       (entry_w[i]),
            .shift       (shift_w[i])
        );
    end

    // fill count and result build
    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.rem)
        begin
            count_next = count_reg - 1'b1;
        end

        result_next               = result_reg;
        result_next.removed_value = cmd.rem ? entry_w[0] : '0;
        result_next.status        = ST_DONE;
        if (accept && (item.action == ACT_INSERT) && full)
        begin
            result_next.status = ST_FULL;
        end
        else if (accept && (item.action == ACT_REMOVE) && empty)
        begin
            result_next.status = ST_EMPTY;
        end
        result_next.entry_count = COUNT_W'(count_next);
        result_next.is_empty    = count_next == '0;

        result_valid_next = result_valid_reg && result_stall;
        if (accept)
        begin
            result_valid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // checks
    `SLIRM_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CAP_CNT, "count above capacity")
    `SLIRM_ASSERT_SAME(a_empty_flag, result_valid_reg, result_reg.is_empty == (count_reg == '0), "empty flag disagrees with count")
    `SLIRM_ASSERT_NEXT(a_remove_empty, accept && item.action == ACT_REMOVE && empty, result_reg.status == ST_EMPTY && $stable(count_reg), "remove on empty not flagged")
    `SLIRM_ASSERT_NEXT(a_insert_full, accept && item.action == ACT_INSERT && full, result_reg.status == ST_FULL && $stable(count_reg), "insert on full not rejected")
endmodule
`default_nettype wire

// File: tb/sorted_store_checker.sv
// Checker for the sorted store: watches item and result transactions,
// predicts each result from its own ascending copy of the store and compares.
// Depends on slirm_pkg for the transaction types.
`timescale 1ns / 100ps
module sorted_store_checker #(
    parameter int CAPACITY = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  slirm_pkg::item_t     item,
    input  logic                 item_valid,
    input  logic                 item_stall,
    input  slirm_pkg::result_t   result,
    input  logic                 result_valid,
    input  logic                 result_stall,
    output int                   fail_count,
    output int                   pending
);
    import slirm_pkg::*;

    // held values, smallest first, so the largest sits at the back
    logic signed [VALUE_W-1:0] held_values[$];
    result_t                   expected_results[$];
    result_t                   oldest;

    // apply one item to the mirrored store and return the result it must give
    function automatic result_t apply_item(item_t it);
        result_t outcome;
        int      slot;
        outcome = '0;
        outcome.status = ST_DONE;
        if (it.action == ACT_INSERT)
        begin
            if (held_values.size() >= CAPACITY)
                outcome.status = ST_FULL;
            else
            begin
                // new value goes after every held value not greater than it
                slot = 0;
                while (slot < held_values.size() && held_values[slot] <= it.value)
                    slot++;
                held_values.insert(slot, it.value);
            end
        end
        else if (held_values.size() == 0)
            outcome.status = ST_EMPTY;
        else
            outcome.removed_value = held_values.pop_back();
        outcome.entry_count = COUNT_W'(held_values.size());
        outcome.is_empty = (held_values.size() == 0);
        return outcome;
    endfunction

    // results are checked before new items are predicted in the same cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_values.delete();
            expected_results.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with no item outstanding");
                    fail_count++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (result.removed_value !== oldest.removed_value)
                    begin
                        $error("removed_value: expected %0d, actual %0d",
                               oldest.removed_value, result.removed_value);
                        fail_count++;
                    end
                    if (result.status !== oldest.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               oldest.status, result.status);
                        fail_count++;
                    end
                    if (result.entry_count !== oldest.entry_count)
                    begin
                        $error("entry_count: expected %0d, actual %0d",
                               oldest.entry_count, result.entry_count);
                        fail_count++;
                    end
                    if (result.is_empty !== oldest.is_empty)
                    begin
                        $error("is_empty: expected %0d, actual %0d",
                               oldest.is_empty, result.is_empty);
                        fail_count++;
                    end
                end
            end
            if (item_valid && !item_stall)
                expected_results.push_back(apply_item(item));
            pending = expected_results.size();
        end
    end
endmodule

// File: tb/testbench.sv
// Top of the sorted store testbench: clock, reset, item stimulus, result stall
// and the verdict. Depends on slirm_pkg, sorted_list_insert_remove_max and
// sorted_store_checker.
`timescale 1ns / 100ps
module testbench;
    import slirm_pkg::*;

    localparam int CAPACITY       = 16;
    localparam int RANDOM_ITEMS   = 1100;
    localparam int WATCHDOG_LIMIT = 2000;

    logic    clk = 1'b0;
    logic    rst_n;
    item_t   item;
    logic    item_valid;
    logic    item_stall;
    result_t result;
    logic    result_valid;
    logic    result_stall;
    int      fail_count;
    int      pending;
    int      quiet_cycles;
    bit      idle_on;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sorted_list_insert_remove_max #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item(item),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .result(result),
        .result_valid(result_valid),
        .result_stall(result_stall)
    );

    sorted_store_checker #(
        .CAPACITY(CAPACITY)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .item(item),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .result(result),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .fail_count(fail_count),
        .pending(pending)
    );

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side stalls in random bursts while idling is on
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // one item transaction, entered and left at a falling edge, valid left high
    task automatic send_item(input item_t next_item);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 5);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item <= next_item;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // hold off the sender until every outstanding result has come back
    task automatic wait_for_results();
        item_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // mix of extremes, tightly clustered values that tie, and full-range values
    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = 32'sh7FFFFFFF;
            1: v = 32'sh80000000;
            2, 3: v = $urandom_range(0, 8) - 4;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    initial
    begin
        logic signed [VALUE_W-1:0] directed_values[16];
        int                        remove_pct;
        action_t                   act;

        rst_n = 1'b0;
        item = '0;
        item_valid = 1'b0;
        idle_on = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: remove on empty, fill with extremes and ties, insert on full, then removes
        directed_values = '{32'sh7FFFFFFF, 32'sh80000000, 0, -1, 1, 7, 7, -7,
                            32'sh55555555, 32'shAAAAAAAA, 32'sh80000000,
                            32'sh7FFFFFFF, 100, -100, 0, 0};
        directed_values[14] = $urandom;
        directed_values[15] = $urandom;
        send_item(item_t'{ACT_REMOVE, 32'sh7FFFFFFF});
        foreach (directed_values[k])
            send_item(item_t'{ACT_INSERT, directed_values[k]});
        send_item(item_t'{ACT_INSERT, 32'sd42});
        repeat (6)
            send_item(item_t'{ACT_REMOVE, $urandom});
        wait_for_results();

        // random: phases that lean toward filling, draining or neither
        remove_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: remove_pct = 15;
                    1: remove_pct = 85;
                    default: remove_pct = 50;
                endcase
            end
            if (n == RANDOM_ITEMS / 2)
                wait_for_results();
            if (n == RANDOM_ITEMS - 150)
                idle_on = 1'b0;
            act = ($urandom_range(0, 99) < remove_pct) ? ACT_REMOVE : ACT_INSERT;
            send_item(item_t'{act, (act == ACT_INSERT) ? pick_value() : $urandom});
        end

        // drain and let the pipeline settle
        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
